### src/aat_pkg.sv
// Shared constants and types for the affine box transform pipeline.
`timescale 1ns / 1ps
`default_nettype none

package aat_pkg;

    localparam int COORD_WIDTH_DEF     = 32;
    localparam int COEFF_WIDTH_DEF     = 16;
    localparam int COEFF_FRAC_BITS_DEF = 12;

    localparam int NUM_AXES   = 3;
    localparam int NUM_STAGES = 5;
    localparam int CFG_IDX_W  = 3;

    // stage positions within the datapath
    localparam int STG_MUL = 0;
    localparam int STG_SEL = 1;
    localparam int STG_ADD = 2;
    localparam int STG_SUM = 3;
    localparam int STG_SAT = 4;

    typedef logic [NUM_STAGES-1:0] t_stage_en;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X   = 3'd0,
        CFG_ROW_Y   = 3'd1,
        CFG_ROW_Z   = 3'd2,
        CFG_SHIFT_X = 3'd3,
        CFG_SHIFT_Y = 3'd4,
        CFG_SHIFT_Z = 3'd5
    } t_cfg_idx;

endpackage

`default_nettype wire

### src/aat_cfg_regs.sv
// Configuration registers: matrix rows and translation.
`timescale 1ns / 1ps
`default_nettype none

module aat_cfg_regs #(
    parameter int COORD_WIDTH     = aat_pkg::COORD_WIDTH_DEF,
    parameter int COEFF_WIDTH     = aat_pkg::COEFF_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = aat_pkg::COEFF_FRAC_BITS_DEF,
    localparam int ROW_W      = 3 * COEFF_WIDTH,
    localparam int CFG_DATA_W = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic [ROW_W-1:0]              o_row   [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] o_shift [aat_pkg::NUM_AXES]
);
    import aat_pkg::*;

    logic [ROW_W-1:0]              r_row   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_shift [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NUM_AXES; a++) begin
                r_row[a]   <= ROW_W'(1) << (a * COEFF_WIDTH + COEFF_FRAC_BITS);
                r_shift[a] <= '0;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROW_X:   r_row[0]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Y:   r_row[1]   <= i_cfg_data[ROW_W-1:0];
                CFG_ROW_Z:   r_row[2]   <= i_cfg_data[ROW_W-1:0];
                CFG_SHIFT_X: r_shift[0] <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                CFG_SHIFT_Y: r_shift[1] <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                CFG_SHIFT_Z: r_shift[2] <= $signed(i_cfg_data[COORD_WIDTH-1:0]);
                default: ;
            endcase
        end
    end

    assign o_row   = r_row;
    assign o_shift = r_shift;

endmodule

`default_nettype wire

### src/aat_axis.sv
// Five-stage datapath for one output axis: multiply, select, partial sums, final sum, round/saturate.
`timescale 1ns / 1ps
`default_nettype none

module aat_axis #(
    parameter int COORD_WIDTH     = aat_pkg::COORD_WIDTH_DEF,
    parameter int COEFF_WIDTH     = aat_pkg::COEFF_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = aat_pkg::COEFF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  aat_pkg::t_stage_en            i_en,
    input  logic [3*COEFF_WIDTH-1:0]      i_row,
    input  logic signed [COORD_WIDTH-1:0] i_shift,
    input  logic signed [COORD_WIDTH-1:0] i_lo [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0] i_hi [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0] o_lo,
    output logic signed [COORD_WIDTH-1:0] o_hi,
    output logic                          o_sat
);
    import aat_pkg::*;

    localparam int F      = COEFF_FRAC_BITS;
    localparam int PROD_W = COEFF_WIDTH + COORD_WIDTH;
    localparam int TR_W   = COORD_WIDTH + F;
    localparam int TERM_W = (PROD_W > TR_W) ? PROD_W : TR_W;
    localparam int ACC_W  = TERM_W + 2;
    localparam int RND_W  = ACC_W - F;
    localparam int TOP_W  = RND_W - COORD_WIDTH + 1;
    localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COEFF_WIDTH-1:0] w_k [NUM_AXES];

    logic signed [PROD_W-1:0] r_p_lo [NUM_AXES];
    logic signed [PROD_W-1:0] r_p_hi [NUM_AXES];
    logic signed [PROD_W-1:0] r_mn   [NUM_AXES];
    logic signed [PROD_W-1:0] r_mx   [NUM_AXES];
    logic signed [ACC_W-1:0]  r_sa_lo, r_sb_lo, r_sa_hi, r_sb_hi;
    logic signed [ACC_W-1:0]  r_sum_lo, r_sum_hi;
    logic signed [COORD_WIDTH-1:0] r_lo, r_hi;
    logic r_sat;

    logic signed [ACC_W-1:0] w_tr;
    logic [RND_W-1:0] w_rnd_lo, w_rnd_hi;
    logic [TOP_W-1:0] w_top_lo, w_top_hi;
    logic w_ovf_lo, w_ovf_hi;
    logic signed [COORD_WIDTH-1:0] n_lo, n_hi;

    always_comb begin
        for (int c = 0; c < NUM_AXES; c++) begin
            w_k[c] = $signed(i_row[c*COEFF_WIDTH +: COEFF_WIDTH]);
        end
    end

    // translation in accumulator scale, with the half-LSB rounding term folded in
    assign w_tr = $signed({{(ACC_W-TR_W){i_shift[COORD_WIDTH-1]}}, i_shift,
                           1'b1, {(F-1){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (i_en[STG_MUL]) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                r_p_lo[c] <= PROD_W'(w_k[c]) * PROD_W'(i_lo[c]);
                r_p_hi[c] <= PROD_W'(w_k[c]) * PROD_W'(i_hi[c]);
            end
        end
        if (i_en[STG_SEL]) begin
            for (int c = 0; c < NUM_AXES; c++) begin
                if (r_p_lo[c] < r_p_hi[c]) begin
                    r_mn[c] <= r_p_lo[c];
                    r_mx[c] <= r_p_hi[c];
                end else begin
                    r_mn[c] <= r_p_hi[c];
                    r_mx[c] <= r_p_lo[c];
                end
            end
        end
        if (i_en[STG_ADD]) begin
            r_sa_lo <= w_tr + ACC_W'(r_mn[0]);
            r_sb_lo <= ACC_W'(r_mn[1]) + ACC_W'(r_mn[2]);
            r_sa_hi <= w_tr + ACC_W'(r_mx[0]);
            r_sb_hi <= ACC_W'(r_mx[1]) + ACC_W'(r_mx[2]);
        end
        if (i_en[STG_SUM]) begin
            r_sum_lo <= r_sa_lo + r_sb_lo;
            r_sum_hi <= r_sa_hi + r_sb_hi;
        end
        if (i_en[STG_SAT]) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_sat <= w_ovf_lo | w_ovf_hi;
        end
    end

    always_comb begin
        w_rnd_lo = r_sum_lo[ACC_W-1:F];
        w_rnd_hi = r_sum_hi[ACC_W-1:F];
        w_top_lo = w_rnd_lo[RND_W-1:COORD_WIDTH-1];
        w_top_hi = w_rnd_hi[RND_W-1:COORD_WIDTH-1];
        w_ovf_lo = !((&w_top_lo) || (~|w_top_lo));
        w_ovf_hi = !((&w_top_hi) || (~|w_top_hi));
        if (w_ovf_lo) begin
            n_lo = w_rnd_lo[RND_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            n_lo = w_rnd_lo[COORD_WIDTH-1:0];
        end
        if (w_ovf_hi) begin
            n_hi = w_rnd_hi[RND_W-1] ? SAT_MIN : SAT_MAX;
        end else begin
            n_hi = w_rnd_hi[COORD_WIDTH-1:0];
        end
    end

    assign o_lo  = r_lo;
    assign o_hi  = r_hi;
    assign o_sat = r_sat;

endmodule

`default_nettype wire

### src/aabb_affine_transform.sv
// Top level: bounding box of an affine-transformed axis-aligned box.
//
// Input channel: i_in_valid with the six box bounds; an item is taken on a
// clock edge where i_in_valid is high and o_in_stall is low.
// Output channel: o_out_valid with the transformed bounds, is_empty and
// saturated; an item leaves on an edge where o_out_valid is high and
// i_out_stall is low.
// Throughput is one item per cycle while the receiver does not stall; the
// five stages (16x32 multiplies, min/max select, partial sums, final sum,
// rounding with saturation) each hold one item.
// Each stage moves when it is empty or the stage after it moves, so while
// the receiver stalls, empty stages in the pipe keep filling and o_in_stall
// rises only once the pipe is full. Nothing is dropped or repeated.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_data) take effect on the
// next edge and are meant to be made while the pipe is empty.
// Reset (i_rst_n low, synchronous) clears all stage valid bits and loads
// the identity matrix with zero translation.
`timescale 1ns / 1ps
`default_nettype none

module aabb_affine_transform #(
    parameter int COORD_WIDTH     = aat_pkg::COORD_WIDTH_DEF,
    parameter int COEFF_WIDTH     = aat_pkg::COEFF_WIDTH_DEF,
    parameter int COEFF_FRAC_BITS = aat_pkg::COEFF_FRAC_BITS_DEF,
    localparam int ROW_W      = 3 * COEFF_WIDTH,
    localparam int CFG_DATA_W = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]         i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_lo_x,
    input  logic signed [COORD_WIDTH-1:0] i_lo_y,
    input  logic signed [COORD_WIDTH-1:0] i_lo_z,
    input  logic signed [COORD_WIDTH-1:0] i_hi_x,
    input  logic signed [COORD_WIDTH-1:0] i_hi_y,
    input  logic signed [COORD_WIDTH-1:0] i_hi_z,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [COORD_WIDTH-1:0] o_out_lo_x,
    output logic signed [COORD_WIDTH-1:0] o_out_lo_y,
    output logic signed [COORD_WIDTH-1:0] o_out_lo_z,
    output logic signed [COORD_WIDTH-1:0] o_out_hi_x,
    output logic signed [COORD_WIDTH-1:0] o_out_hi_y,
    output logic signed [COORD_WIDTH-1:0] o_out_hi_z,
    output logic                          o_is_empty,
    output logic                          o_saturated
);
    import aat_pkg::*;

    localparam logic [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [ROW_W-1:0]              w_row   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_shift [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_in_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_in_hi [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_out_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_out_hi [NUM_AXES];
    logic [NUM_AXES-1:0]           w_sat;

    t_stage_en             w_en;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] r_empty;
    logic                  w_empty_in;

    aat_cfg_regs #(
        .COORD_WIDTH     (COORD_WIDTH),
        .COEFF_WIDTH     (COEFF_WIDTH),
        .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_row      (w_row),
        .o_shift    (w_shift)
    );

    assign w_in_lo[0] = i_lo_x;
    assign w_in_lo[1] = i_lo_y;
    assign w_in_lo[2] = i_lo_z;
    assign w_in_hi[0] = i_hi_x;
    assign w_in_hi[1] = i_hi_y;
    assign w_in_hi[2] = i_hi_z;

    assign w_empty_in = (i_hi_x < i_lo_x) || (i_hi_y < i_lo_y) || (i_hi_z < i_lo_z);

    // a stage loads when it holds nothing or its item moves on
    always_comb begin
        w_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int s = NUM_STAGES - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NUM_STAGES; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_empty[0] <= w_empty_in;
        end
        for (int s = 1; s < NUM_STAGES; s++) begin
            if (w_en[s]) begin
                r_empty[s] <= r_empty[s-1];
            end
        end
    end

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        aat_axis #(
            .COORD_WIDTH     (COORD_WIDTH),
            .COEFF_WIDTH     (COEFF_WIDTH),
            .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
        ) u_axis (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_row   (w_row[a]),
            .i_shift (w_shift[a]),
            .i_lo    (w_in_lo),
            .i_hi    (w_in_hi),
            .o_lo    (w_out_lo[a]),
            .o_hi    (w_out_hi[a]),
            .o_sat   (w_sat[a])
        );
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[NUM_STAGES-1];
    assign o_is_empty  = r_empty[NUM_STAGES-1];
    assign o_saturated = !r_empty[NUM_STAGES-1] && (|w_sat);

    assign o_out_lo_x = r_empty[NUM_STAGES-1] ? SAT_MAX : w_out_lo[0];
    assign o_out_lo_y = r_empty[NUM_STAGES-1] ? SAT_MAX : w_out_lo[1];
    assign o_out_lo_z = r_empty[NUM_STAGES-1] ? SAT_MAX : w_out_lo[2];
    assign o_out_hi_x = r_empty[NUM_STAGES-1] ? SAT_MIN : w_out_hi[0];
    assign o_out_hi_y = r_empty[NUM_STAGES-1] ? SAT_MIN : w_out_hi[1];
    assign o_out_hi_z = r_empty[NUM_STAGES-1] ? SAT_MIN : w_out_hi[2];

endmodule

`default_nettype wire

### dv/aat_box_checker.sv
// Scoreboard for the affine box transform: predicts every transformed box and checks results.
`timescale 1ns / 1ps

module aat_box_checker #(
    parameter int CW    = aat_pkg::COORD_WIDTH_DEF,
    parameter int KW    = aat_pkg::COEFF_WIDTH_DEF,
    parameter int FB    = aat_pkg::COEFF_FRAC_BITS_DEF,
    parameter int CFG_W = (3 * KW > CW) ? 3 * KW : CW
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [CW-1:0]                 i_lo_x,
    input  logic [CW-1:0]                 i_lo_y,
    input  logic [CW-1:0]                 i_lo_z,
    input  logic [CW-1:0]                 i_hi_x,
    input  logic [CW-1:0]                 i_hi_y,
    input  logic [CW-1:0]                 i_hi_z,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [CW-1:0]                 i_out_lo_x,
    input  logic [CW-1:0]                 i_out_lo_y,
    input  logic [CW-1:0]                 i_out_lo_z,
    input  logic [CW-1:0]                 i_out_hi_x,
    input  logic [CW-1:0]                 i_out_hi_y,
    input  logic [CW-1:0]                 i_out_hi_z,
    input  logic                          i_out_empty,
    input  logic                          i_out_saturated,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_empty_seen,
    output int                            o_sat_seen
);

    import aat_pkg::*;

    localparam int ROW_W        = 3 * KW;
    localparam int REPORT_LIMIT = 10;
    localparam logic signed [63:0] BOUND_HI   = (64'sd1 <<< (CW - 1)) - 64'sd1;
    localparam logic signed [63:0] BOUND_LO   = -(64'sd1 <<< (CW - 1));
    localparam logic signed [63:0] ROUND_HALF = 64'sd1 <<< (FB - 1);

    typedef struct packed {
        logic [2:0][CW-1:0] lo;
        logic [2:0][CW-1:0] hi;
        logic               empty;
        logic               sat;
    } t_box;

    logic [ROW_W-1:0] coeff_row [3];
    logic [CW-1:0]    offset [3];
    t_box             expected_boxes [$];

    function automatic logic [CW-1:0] round_clamp(input logic signed [63:0] acc,
                                                  inout logic sat);
        logic signed [63:0] v;
        v = (acc + ROUND_HALF) >>> FB;
        if (v > BOUND_HI) begin
            sat = 1'b1;
            return BOUND_HI[CW-1:0];
        end
        if (v < BOUND_LO) begin
            sat = 1'b1;
            return BOUND_LO[CW-1:0];
        end
        return v[CW-1:0];
    endfunction

    function automatic t_box transform_box(input logic [2:0][CW-1:0] lo,
                                           input logic [2:0][CW-1:0] hi);
        t_box                r;
        logic                sat;
        logic signed [63:0]  acc_lo, acc_hi, p_lo, p_hi;
        logic signed [KW-1:0] k;
        logic signed [CW-1:0] a_lo, a_hi;
        int                  o, c;
        r = '0;
        sat = 1'b0;
        for (c = 0; c < 3; c++) begin
            if ($signed(hi[c]) < $signed(lo[c])) r.empty = 1'b1;
        end
        if (r.empty) begin
            r.lo = {3{BOUND_HI[CW-1:0]}};
            r.hi = {3{BOUND_LO[CW-1:0]}};
            return r;
        end
        for (o = 0; o < 3; o++) begin
            acc_lo = $signed(offset[o]);
            acc_lo = acc_lo <<< FB;
            acc_hi = acc_lo;
            for (c = 0; c < 3; c++) begin
                k = coeff_row[o][c*KW +: KW];
                a_lo = lo[c];
                a_hi = hi[c];
                p_lo = k * a_lo;
                p_hi = k * a_hi;
                if (p_lo < p_hi) begin
                    acc_lo += p_lo;
                    acc_hi += p_hi;
                end else begin
                    acc_lo += p_hi;
                    acc_hi += p_lo;
                end
            end
            r.lo[o] = round_clamp(acc_lo, sat);
            r.hi[o] = round_clamp(acc_hi, sat);
        end
        r.sat = sat;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [CW-1:0] want,
                               input logic [CW-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            if (o_fail_count <= REPORT_LIMIT)
                $display("[%0t] result %0d %s: expected %h, got %h",
                         $realtime, o_checked, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_box got, want;
        if (!i_rst_n) begin
            coeff_row[0] = ROW_W'(1) << FB;
            coeff_row[1] = ROW_W'(1) << (FB + KW);
            coeff_row[2] = ROW_W'(1) << (FB + 2 * KW);
            offset[0] = '0;
            offset[1] = '0;
            offset[2] = '0;
            expected_boxes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got.lo = {i_out_lo_z, i_out_lo_y, i_out_lo_x};
                got.hi = {i_out_hi_z, i_out_hi_y, i_out_hi_x};
                got.empty = i_out_empty;
                got.sat = i_out_saturated;
                if (expected_boxes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= REPORT_LIMIT)
                        $display("[%0t] unexpected result: lo %h hi %h", $realtime,
                                 got.lo, got.hi);
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("lo_x", want.lo[0], got.lo[0]);
                    check_field("lo_y", want.lo[1], got.lo[1]);
                    check_field("lo_z", want.lo[2], got.lo[2]);
                    check_field("hi_x", want.hi[0], got.hi[0]);
                    check_field("hi_y", want.hi[1], got.hi[1]);
                    check_field("hi_z", want.hi[2], got.hi[2]);
                    check_field("is_empty", CW'(want.empty), CW'(got.empty));
                    check_field("saturated", CW'(want.sat), CW'(got.sat));
                    o_checked++;
                    if (want.empty) o_empty_seen++;
                    if (want.sat) o_sat_seen++;
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_boxes.push_back(transform_box({i_lo_z, i_lo_y, i_lo_x},
                                                       {i_hi_z, i_hi_y, i_hi_x}));
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_ROW_X:   coeff_row[0] = i_cfg_data[ROW_W-1:0];
                    CFG_ROW_Y:   coeff_row[1] = i_cfg_data[ROW_W-1:0];
                    CFG_ROW_Z:   coeff_row[2] = i_cfg_data[ROW_W-1:0];
                    CFG_SHIFT_X: offset[0] = i_cfg_data[CW-1:0];
                    CFG_SHIFT_Y: offset[1] = i_cfg_data[CW-1:0];
                    CFG_SHIFT_Z: offset[2] = i_cfg_data[CW-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_boxes.size();
    end

endmodule

### dv/testbench.sv
// Testbench top for the affine box transform: stimulus, pacing, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;

    import aat_pkg::*;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int KW          = COEFF_WIDTH_DEF;
    localparam int FB          = COEFF_FRAC_BITS_DEF;
    localparam int ROW_W       = 3 * KW;
    localparam int CFG_W       = (ROW_W > CW) ? ROW_W : CW;
    localparam int LATENCY     = NUM_STAGES;
    localparam int STALL_LIMIT = 2000;
    localparam int NUM_PHASES  = 8;
    localparam int PHASE_ITEMS = 48;
    localparam int TIE         = 1 << (FB - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = CFG_IDX_W'(CFG_SHIFT_Z + 1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = CFG_IDX_W'(CFG_SHIFT_Z + 2);

    localparam logic [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};
    localparam logic [KW-1:0] K_MAX = {1'b0, {(KW-1){1'b1}}};
    localparam logic [KW-1:0] K_MIN = {1'b1, {(KW-1){1'b0}}};
    localparam logic [2:0][ROW_W-1:0] IDENTITY_ROWS = {ROW_W'(1) << (FB + 2 * KW),
                                                       ROW_W'(1) << (FB + KW),
                                                       ROW_W'(1) << FB};
    localparam logic [2:0][ROW_W-1:0] LSB_ROWS = {ROW_W'(1) << (2 * KW),
                                                  ROW_W'(1) << KW,
                                                  ROW_W'(1)};

    typedef enum int {SPREAD_FULL, SPREAD_MODERATE, SPREAD_EDGE} t_spread;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic signed [CW-1:0] i_lo_x, i_lo_y, i_lo_z, i_hi_x, i_hi_y, i_hi_z;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic signed [CW-1:0] o_out_lo_x, o_out_lo_y, o_out_lo_z;
    logic signed [CW-1:0] o_out_hi_x, o_out_hi_y, o_out_hi_z;
    logic                 o_is_empty;
    logic                 o_saturated;

    int fail_count, pending, checked, empties, saturations;
    int boxes_sent, settings_loaded, idle_cycles;
    bit steady;

    aabb_affine_transform u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_lo_x      (i_lo_x),
        .i_lo_y      (i_lo_y),
        .i_lo_z      (i_lo_z),
        .i_hi_x      (i_hi_x),
        .i_hi_y      (i_hi_y),
        .i_hi_z      (i_hi_z),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_lo_x  (o_out_lo_x),
        .o_out_lo_y  (o_out_lo_y),
        .o_out_lo_z  (o_out_lo_z),
        .o_out_hi_x  (o_out_hi_x),
        .o_out_hi_y  (o_out_hi_y),
        .o_out_hi_z  (o_out_hi_z),
        .o_is_empty  (o_is_empty),
        .o_saturated (o_saturated)
    );

    aat_box_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_lo_x          (i_lo_x),
        .i_lo_y          (i_lo_y),
        .i_lo_z          (i_lo_z),
        .i_hi_x          (i_hi_x),
        .i_hi_y          (i_hi_y),
        .i_hi_z          (i_hi_z),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_out_lo_x      (o_out_lo_x),
        .i_out_lo_y      (o_out_lo_y),
        .i_out_lo_z      (o_out_lo_z),
        .i_out_hi_x      (o_out_hi_x),
        .i_out_hi_y      (o_out_hi_y),
        .i_out_hi_z      (o_out_hi_z),
        .i_out_empty     (o_is_empty),
        .i_out_saturated (o_saturated),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_empty_seen    (empties),
        .o_sat_seen      (saturations)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver pacing: mostly short stalls, some long ones, free-running stretches
    initial begin : rx_pacing
        int hold;
        int r;
        i_out_stall = 1'b0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (steady) begin
                i_out_stall <= 1'b0;
                hold = 0;
            end else if (hold > 0) begin
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    i_out_stall <= 1'b0;
                    hold = $urandom_range(0, 20);
                end else if (r < 90) begin
                    i_out_stall <= 1'b1;
                    hold = $urandom_range(0, 2);
                end else begin
                    i_out_stall <= 1'b1;
                    hold = $urandom_range(8, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [CW-1:0] rand_coord(t_spread spread);
        logic [31:0] v;
        v = $urandom;
        case (spread)
            SPREAD_MODERATE: return {{(CW-20){v[19]}}, v[19:0]};
            SPREAD_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return C_MAX - CW'($urandom_range(0, 3));
                    1: return C_MIN + CW'($urandom_range(0, 3));
                    2: return '0;
                    3: return '1;
                    4: return C_MAX;
                    default: return C_MIN;
                endcase
            end
            default: return CW'({$urandom, v});
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row(t_spread spread);
        logic [ROW_W-1:0] row;
        logic [31:0]      v;
        int               c;
        for (c = 0; c < 3; c++) begin
            v = $urandom;
            if (spread == SPREAD_MODERATE && $urandom_range(0, 4) == 0)
                row[c*KW +: KW] = '0;
            else if (spread == SPREAD_MODERATE)
                row[c*KW +: KW] = {{(KW-FB-2){v[FB+1]}}, v[FB+1:0]};
            else
                row[c*KW +: KW] = v[KW-1:0];
        end
        return row;
    endfunction

    function automatic logic [CW-1:0] rand_offset(t_spread spread);
        logic [31:0] v;
        v = $urandom;
        if (spread == SPREAD_MODERATE) return {{(CW-24){v[23]}}, v[23:0]};
        return CW'({$urandom, v});
    endfunction

    // offsets carry random junk above their width, which the block must drop
    function automatic logic [CFG_W-1:0] pad_offset(logic [CW-1:0] off);
        logic [CFG_W-1:0] v;
        v = CFG_W'({$urandom, $urandom});
        v[CW-1:0] = off;
        return v;
    endfunction

    task automatic random_box(output logic [2:0][CW-1:0] lo, output logic [2:0][CW-1:0] hi);
        logic [CW-1:0] p, q;
        t_spread       spread;
        int            a, form;
        form = $urandom_range(0, 99);
        for (a = 0; a < 3; a++) begin
            spread = t_spread'($urandom_range(0, 2));
            p = rand_coord(spread);
            q = ($urandom_range(0, 9) == 0) ? p : rand_coord(spread);
            if ($signed(p) > $signed(q)) begin
                lo[a] = q;
                hi[a] = p;
            end else begin
                lo[a] = p;
                hi[a] = q;
            end
        end
        if (form < 4) begin
            lo = {$urandom, $urandom, $urandom};
            hi = {$urandom, $urandom, $urandom};
        end else if (form < 12) begin
            a = $urandom_range(0, 2);
            if (lo[a] == hi[a]) begin
                lo[a] = C_MAX;
                hi[a] = C_MIN;
            end else begin
                p = lo[a];
                lo[a] = hi[a];
                hi[a] = p;
            end
        end
    endtask

    task automatic send_box(input logic [2:0][CW-1:0] lo, input logic [2:0][CW-1:0] hi);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_lo_z, i_lo_y, i_lo_x} <= lo;
        {i_hi_z, i_hi_y, i_hi_x} <= hi;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
        boxes_sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic load_regs(input logic [2:0][ROW_W-1:0] rows,
                             input logic [2:0][CW-1:0] offs);
        logic [CFG_IDX_W-1:0] idx [8];
        logic [CFG_W-1:0]     val [8];
        int                   n;
        idx = '{CFG_ROW_X, CFG_ROW_Y, CFG_SPARE_A, CFG_ROW_Z,
                CFG_SHIFT_X, CFG_SHIFT_Y, CFG_SPARE_B, CFG_SHIFT_Z};
        val[0] = CFG_W'(rows[0]);
        val[1] = CFG_W'(rows[1]);
        val[2] = CFG_W'({$urandom, $urandom});
        val[3] = CFG_W'(rows[2]);
        val[4] = pad_offset(offs[0]);
        val[5] = pad_offset(offs[1]);
        val[6] = CFG_W'({$urandom, $urandom});
        val[7] = pad_offset(offs[2]);
        for (n = 0; n < 8; n++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[n];
            i_cfg_data <= val[n];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_loaded++;
    endtask

    initial begin : stimulus
        logic [2:0][CW-1:0]    lo, hi;
        logic [2:0][ROW_W-1:0] rows;
        logic [2:0][CW-1:0]    offs;
        t_spread               spread;
        int                    a, ph, n;

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_ROW_X;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        {i_lo_x, i_lo_y, i_lo_z, i_hi_x, i_hi_y, i_hi_z} = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // identity transform straight out of reset
        send_box('0, '0);
        send_box({3{C_MIN}}, {3{C_MAX}});
        send_box({3{C_MAX}}, {3{C_MAX}});
        send_box({3{C_MIN}}, {3{C_MIN}});
        send_box({3{-CW'(1)}}, {3{CW'(1)}});
        for (a = 0; a < 3; a++) begin
            lo = '0;
            hi = '0;
            hi[a] = '1;
            send_box(lo, hi);
        end
        send_box({3{C_MAX}}, {3{C_MIN}});

        // largest coefficients and shifts: clamps high and low
        drain();
        load_regs({3{{3{K_MAX}}}}, {3{C_MAX}});
        send_box({3{C_MIN}}, {3{C_MAX}});
        send_box('0, '0);

        // most negative coefficients: min and max products swap
        drain();
        load_regs({3{{3{K_MIN}}}}, {3{C_MIN}});
        send_box({3{C_MIN}}, {3{C_MAX}});
        send_box({3{C_MAX}}, {3{C_MAX}});

        // one-LSB diagonal: exercises round-half-up on both signs
        drain();
        load_regs(LSB_ROWS, '0);
        send_box({3{CW'(-TIE)}}, {3{CW'(TIE)}});
        send_box({3{CW'(-TIE - 1)}}, {3{CW'(3 * TIE - 1)}});

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            case (ph)
                0: begin
                    rows = IDENTITY_ROWS;
                    offs = '0;
                end
                3: begin
                    rows = {3{{3{K_MAX}}}};
                    offs = {3{C_MAX}};
                end
                4: begin
                    rows = '0;
                    for (a = 0; a < 3; a++) offs[a] = rand_offset(SPREAD_FULL);
                end
                6: begin
                    rows = {3{{3{K_MIN}}}};
                    offs = {3{C_MIN}};
                end
                default: begin
                    spread = (ph == 2 || ph == 7) ? SPREAD_FULL : SPREAD_MODERATE;
                    for (a = 0; a < 3; a++) begin
                        rows[a] = rand_row(spread);
                        offs[a] = rand_offset(ph == 7 ? SPREAD_MODERATE : spread);
                    end
                end
            endcase
            load_regs(rows, offs);
            steady = (ph == 2);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                random_box(lo, hi);
                send_box(lo, hi);
            end
            steady = 1'b0;
        end

        drain();
        repeat (2 * LATENCY) @(negedge i_clk);
        $display("Sent %0d boxes under %0d register settings; %0d results checked.",
                 boxes_sent, settings_loaded, checked);
        $display("Of those, %0d were empty boxes and %0d had clamped bounds; %0d mismatches.",
                 empties, saturations, fail_count);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/aat_pkg.sv
src/aat_cfg_regs.sv
src/aat_axis.sv
src/aabb_affine_transform.sv
dv/aat_box_checker.sv
dv/testbench.sv
